[hw/rtl/scu_pkg.sv]
// Shared types, codes and float compare helpers for the SIMD compare unit.
package scu_pkg;

  typedef enum logic [2:0] {
    OP_INT_EQ  = 3'd0,
    OP_INT_GT  = 3'd1,
    OP_FP_PACK = 3'd2,
    OP_FP_SCAL = 3'd3,
    OP_COMIS   = 3'd4,
    OP_PTEST   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PR_EQ    = 3'd0,
    PR_LT    = 3'd1,
    PR_LE    = 3'd2,
    PR_UNORD = 3'd3,
    PR_NEQ   = 3'd4,
    PR_NLT   = 3'd5,
    PR_NLE   = 3'd6,
    PR_ORD   = 3'd7
  } pred_t;

  localparam int unsigned LaneW = 64;

  // Relation of two float operands.
  typedef struct packed {
    logic eq;
    logic lt;
    logic unord;
  } fcmp_t;

  // Control that every lane sees.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] lane_size;
    logic       is_double;
    logic [2:0] pred;
  } lane_ctl_t;

  // Per-lane findings passed to the merge stage.
  typedef struct packed {
    logic [LaneW-1:0] mask;     // vector result for this lane word
    fcmp_t            rel;      // scalar relation of the low element
    logic             and_nz;   // A & B nonzero in this word
    logic             andn_nz;  // ~A & B nonzero in this word
  } lane_res_t;

  function automatic logic pred_eval(fcmp_t c, logic [2:0] p);
    logic r;
    case (p)
      PR_EQ:    r = c.eq;
      PR_LT:    r = c.lt;
      PR_LE:    r = c.lt | c.eq;
      PR_UNORD: r = c.unord;
      PR_NEQ:   r = ~c.eq;
      PR_NLT:   r = ~c.lt;
      PR_NLE:   r = ~(c.lt | c.eq);
      default:  r = ~c.unord;
    endcase
    return r;
  endfunction

  // Single compare: sign-magnitude mapped to an unsigned order key.
  function automatic fcmp_t fcmp_s(logic [31:0] a, logic [31:0] b);
    fcmp_t r;
    logic [31:0] ka, kb;
    r.unord = (a[30:0] > 31'h7F800000) || (b[30:0] > 31'h7F800000);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (r.unord) begin
      r.eq = 1'b0;
      r.lt = 1'b0;
    end else if (a[30:0] == '0 && b[30:0] == '0) begin
      r.eq = 1'b1;
      r.lt = 1'b0;
    end else begin
      r.eq = (ka == kb);
      r.lt = (ka < kb);
    end
    return r;
  endfunction

  function automatic fcmp_t fcmp_d(logic [63:0] a, logic [63:0] b);
    fcmp_t r;
    logic [63:0] ka, kb;
    r.unord = (a[62:0] > 63'h7FF0000000000000) || (b[62:0] > 63'h7FF0000000000000);
    ka = a[63] ? ~a : {1'b1, a[62:0]};
    kb = b[63] ? ~b : {1'b1, b[62:0]};
    if (r.unord) begin
      r.eq = 1'b0;
      r.lt = 1'b0;
    end else if (a[62:0] == '0 && b[62:0] == '0) begin
      r.eq = 1'b1;
      r.lt = 1'b0;
    end else begin
      r.eq = (ka == kb);
      r.lt = (ka < kb);
    end
    return r;
  endfunction

endpackage

[hw/rtl/scu_lane.sv]
// One 64-bit compare lane: integer, float and test work on one word of A and B.
module scu_lane (
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  scu_pkg::lane_ctl_t ctl,
  output scu_pkg::lane_res_t res
);
  import scu_pkg::*;

  logic [7:0]  eq8, gt8;
  logic [3:0]  eq16, gt16;
  logic [1:0]  eq32, gt32;
  logic        eq64, gt64;
  logic [63:0] int_mask;
  fcmp_t       c_lo, c_hi, c_d;
  logic [63:0] fp_mask;

  // Element compares at each integer width.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      eq8[i] = a[8*i +: 8] == b[8*i +: 8];
      gt8[i] = $signed(a[8*i +: 8]) > $signed(b[8*i +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      eq16[i] = a[16*i +: 16] == b[16*i +: 16];
      gt16[i] = $signed(a[16*i +: 16]) > $signed(b[16*i +: 16]);
    end
    for (int i = 0; i < 2; i++) begin
      eq32[i] = a[32*i +: 32] == b[32*i +: 32];
      gt32[i] = $signed(a[32*i +: 32]) > $signed(b[32*i +: 32]);
    end
    eq64 = a == b;
    gt64 = $signed(a) > $signed(b);
  end

  // Spread element hits to byte masks.
  always_comb begin
    int_mask = '0;
    for (int i = 0; i < 8; i++) begin
      case (ctl.lane_size)
        2'd0:    int_mask[8*i +: 8] = {8{(ctl.op == OP_INT_GT) ? gt8[i] : eq8[i]}};
        2'd1:    int_mask[8*i +: 8] = {8{(ctl.op == OP_INT_GT) ? gt16[i/2] : eq16[i/2]}};
        2'd2:    int_mask[8*i +: 8] = {8{(ctl.op == OP_INT_GT) ? gt32[i/4] : eq32[i/4]}};
        default: int_mask[8*i +: 8] = {8{(ctl.op == OP_INT_GT) ? gt64 : eq64}};
      endcase
    end
  end

  // Float compares.
  always_comb begin
    c_lo = fcmp_s(a[31:0], b[31:0]);
    c_hi = fcmp_s(a[63:32], b[63:32]);
    c_d  = fcmp_d(a, b);
    if (ctl.is_double) begin
      fp_mask = {64{pred_eval(c_d, ctl.pred)}};
    end else begin
      fp_mask = {{32{pred_eval(c_hi, ctl.pred)}}, {32{pred_eval(c_lo, ctl.pred)}}};
    end
  end

  always_comb begin
    res.mask    = (ctl.op == OP_INT_EQ || ctl.op == OP_INT_GT) ? int_mask : fp_mask;
    res.rel     = ctl.is_double ? c_d : c_lo;
    res.and_nz  = |(a & b);
    res.andn_nz = |(~a & b);
  end

endmodule

[hw/rtl/scu_merge.sv]
// Merge stage: combines the two lane results into the result vector and flags.
module scu_merge (
  input  scu_pkg::lane_ctl_t ctl,
  input  scu_pkg::lane_res_t res_lo,
  input  scu_pkg::lane_res_t res_hi,
  input  logic [63:0]        a_lo,
  input  logic [63:0]        a_hi,
  output logic [63:0]        result_lo,
  output logic [63:0]        result_hi,
  output logic               flags_written,
  output logic               zero_flag,
  output logic               carry_flag,
  output logic               parity_flag
);
  import scu_pkg::*;

  logic hit;

  always_comb begin
    hit           = pred_eval(res_lo.rel, ctl.pred);
    result_lo     = '0;
    result_hi     = '0;
    flags_written = 1'b0;
    zero_flag     = 1'b0;
    carry_flag    = 1'b0;
    parity_flag   = 1'b0;
    case (ctl.op)
      OP_INT_EQ, OP_INT_GT, OP_FP_PACK: begin
        result_lo = res_lo.mask;
        result_hi = res_hi.mask;
      end
      OP_FP_SCAL: begin
        result_lo = ctl.is_double ? {64{hit}} : {a_lo[63:32], {32{hit}}};
        result_hi = a_hi;
      end
      OP_COMIS: begin
        flags_written = 1'b1;
        zero_flag     = res_lo.rel.eq | res_lo.rel.unord;
        carry_flag    = res_lo.rel.lt | res_lo.rel.unord;
        parity_flag   = res_lo.rel.unord;
      end
      OP_PTEST: begin
        flags_written = 1'b1;
        zero_flag     = ~(res_lo.and_nz | res_hi.and_nz);
        carry_flag    = ~(res_lo.andn_nz | res_hi.andn_nz);
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/simd_compare_unit_core.sv]
// Top level of the SIMD compare unit: two lanes, merge, output register.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, op, lane_size, is_double, pred, a_*, b_*
//  out     | output    | out_valid, out_stall, result_*, flags_written, *_flag
//
// One beat per cycle while the output is not stalled; a result appears in the cycle after its input beat is taken.
// The lanes and merge are combinational; the single output register follows them.
// The input is stalled only while the output register holds a beat that is stalled.
// Reset clears out_valid; the payload register is not reset.
module simd_compare_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [1:0]  lane_size,
  input  logic        is_double,
  input  logic [2:0]  pred,
  input  logic [63:0] a_lo,
  input  logic [63:0] a_hi,
  input  logic [63:0] b_lo,
  input  logic [63:0] b_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi,
  output logic        flags_written,
  output logic        zero_flag,
  output logic        carry_flag,
  output logic        parity_flag
);
  import scu_pkg::*;

  lane_ctl_t   ctl;
  lane_res_t   res_lo, res_hi;
  logic [63:0] m_lo, m_hi;
  logic        m_fw, m_zf, m_cf, m_pf;
  logic        load;

  assign ctl = '{op: op, lane_size: lane_size, is_double: is_double, pred: pred};

  scu_lane u_lane_lo (.a(a_lo), .b(b_lo), .ctl(ctl), .res(res_lo));
  scu_lane u_lane_hi (.a(a_hi), .b(b_hi), .ctl(ctl), .res(res_hi));

  scu_merge u_merge (
    .ctl(ctl), .res_lo(res_lo), .res_hi(res_hi), .a_lo(a_lo), .a_hi(a_hi),
    .result_lo(m_lo), .result_hi(m_hi), .flags_written(m_fw),
    .zero_flag(m_zf), .carry_flag(m_cf), .parity_flag(m_pf)
  );

  // Output register: take a new beat when empty or draining.
  assign in_stall = out_valid & out_stall;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_lo     <= m_lo;
      result_hi     <= m_hi;
      flags_written <= m_fw;
      zero_flag     <= m_zf;
      carry_flag    <= m_cf;
      parity_flag   <= m_pf;
    end
  end

endmodule

[hw/rtl/scu_checker.sv]
// Port-level checks for the SIMD compare unit, bound to the top level.
module scu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_lo,
  input logic [63:0] result_hi,
  input logic        flags_written,
  input logic        parity_flag
);
  import scu_pkg::*;

  // An accepted beat shows up on the output the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid) else $error("beat lost");

  // Flag ops give a zero vector.
  a_flagvec: assert property (@(posedge clk) disable iff (rst)
    out_valid && flags_written |-> result_lo == '0 && result_hi == '0)
    else $error("flag op with vector");

  // PF only with flag ops.
  a_pf: assert property (@(posedge clk) disable iff (rst)
    out_valid && parity_flag |-> flags_written) else $error("stray PF");

  // Comis or ptest beat sets flags_written.
  a_fw: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == OP_COMIS || op == OP_PTEST) |=> flags_written)
    else $error("flags_written missing");

  // out_valid and result_lo held while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_lo))
    else $error("stalled beat changed");

endmodule

bind simd_compare_unit_core scu_checker u_scu_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
  .out_valid(out_valid), .out_stall(out_stall), .result_lo(result_lo),
  .result_hi(result_hi), .flags_written(flags_written), .parity_flag(parity_flag)
);

[verif/simd_compare_unit_core_test.sv]
// Self-checking testbench for the SIMD compare unit: directed table, then random beats.
module simd_compare_unit_core_test;
  import scu_pkg::*;

  localparam int unsigned NumRandom = 400;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [63:0] Ones = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QNanD = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SNanD = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] InfD = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegZD = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OneD = 64'h3FF0_0000_0000_0000;

  // One input beat.
  typedef struct {
    logic [2:0] op;
    logic [1:0] lsz;
    logic dbl;
    logic [2:0] pr;
    logic [63:0] alo, ahi, blo, bhi;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [63:0] rlo, rhi;
    logic fw, zf, cf, pf;
  } res_t;

  // Directed row: known flags set when expectation is written out.
  typedef struct {
    cmd_t c;
    bit known;
    res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [1:0] lane_size = '0;
  logic is_double = 1'b0;
  logic [2:0] pred = '0;
  logic [63:0] a_lo = '0, a_hi = '0, b_lo = '0, b_hi = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [63:0] result_lo, result_hi;
  logic flags_written, zero_flag, carry_flag, parity_flag;

  res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always #4 clk = ~clk;

  simd_compare_unit_core dut (.*);

  // Float relation of two bit patterns, single in the low 32 bits.
  function automatic fcmp_t float_relation(logic [63:0] a, logic [63:0] b, logic dbl);
    fcmp_t r;
    logic [63:0] sgn, inf, msk, ma, mb, ka, kb;
    msk = dbl ? Ones : 64'hFFFF_FFFF;
    sgn = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    inf = dbl ? InfD : 64'h7F80_0000;
    a &= msk;
    b &= msk;
    ma = a & ~sgn;
    mb = b & ~sgn;
    r = '0;
    r.unord = (ma > inf) || (mb > inf);
    if (r.unord) return r;
    if (ma == 0 && mb == 0) begin
      r.eq = 1'b1;
      return r;
    end
    ka = (a & sgn) != 0 ? (~a & msk) : (a | sgn);
    kb = (b & sgn) != 0 ? (~b & msk) : (b | sgn);
    r.eq = (ka == kb);
    r.lt = (ka < kb);
    return r;
  endfunction

  function automatic logic pred_holds(fcmp_t c, logic [2:0] p);
    case (pred_t'(p))
      PR_EQ:    return c.eq;
      PR_LT:    return c.lt;
      PR_LE:    return c.lt | c.eq;
      PR_UNORD: return c.unord;
      PR_NEQ:   return ~c.eq;
      PR_NLT:   return ~c.lt;
      PR_NLE:   return ~(c.lt | c.eq);
      default:  return ~c.unord;
    endcase
  endfunction

  // Integer lane mask over one 64-bit word.
  function automatic logic [63:0] int_lane_mask(logic [63:0] a, logic [63:0] b,
                                                logic [1:0] lsz, logic gt);
    logic [63:0] res, m, la, lb, sb;
    int w;
    w = 8 << lsz;
    m = (w == 64) ? Ones : ((64'd1 << w) - 1);
    sb = 64'd1 << (w - 1);
    res = '0;
    for (int sh = 0; sh < 64; sh += w) begin
      la = (a >> sh) & m;
      lb = (b >> sh) & m;
      if (gt ? ((la ^ sb) > (lb ^ sb)) : (la == lb)) res |= m << sh;
    end
    return res;
  endfunction

  function automatic logic [63:0] float_lane_mask(logic [63:0] a, logic [63:0] b,
                                                  logic dbl, logic [2:0] p);
    if (dbl) return pred_holds(float_relation(a, b, 1'b1), p) ? Ones : '0;
    return {pred_holds(float_relation(a >> 32, b >> 32, 1'b0), p) ? 32'hFFFF_FFFF : 32'h0,
            pred_holds(float_relation(a, b, 1'b0), p) ? 32'hFFFF_FFFF : 32'h0};
  endfunction

  function automatic res_t compare_result(cmd_t c);
    res_t r;
    fcmp_t rel;
    logic hit;
    r = '{default: '0};
    case (c.op)
      OP_INT_EQ, OP_INT_GT: begin
        r.rlo = int_lane_mask(c.alo, c.blo, c.lsz, c.op == OP_INT_GT);
        r.rhi = int_lane_mask(c.ahi, c.bhi, c.lsz, c.op == OP_INT_GT);
      end
      OP_FP_PACK: begin
        r.rlo = float_lane_mask(c.alo, c.blo, c.dbl, c.pr);
        r.rhi = float_lane_mask(c.ahi, c.bhi, c.dbl, c.pr);
      end
      OP_FP_SCAL: begin
        hit = pred_holds(float_relation(c.alo, c.blo, c.dbl), c.pr);
        r.rlo = c.dbl ? (hit ? Ones : '0) : {c.alo[63:32], hit ? 32'hFFFF_FFFF : 32'h0};
        r.rhi = c.ahi;
      end
      OP_COMIS: begin
        rel = float_relation(c.alo, c.blo, c.dbl);
        r.fw = 1'b1;
        r.zf = rel.eq | rel.unord;
        r.cf = rel.lt | rel.unord;
        r.pf = rel.unord;
      end
      OP_PTEST: begin
        r.fw = 1'b1;
        r.zf = ((c.alo & c.blo) | (c.ahi & c.bhi)) == 0;
        r.cf = ((~c.alo & c.blo) | (~c.ahi & c.bhi)) == 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Float operand biased toward the special encodings.
  function automatic logic [63:0] float_operand(logic dbl);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 9))
      0: v = dbl ? QNanD : {v[63:32], 32'h7FC0_0000};
      1: v = dbl ? SNanD : {v[63:32], 32'h7F80_0001};
      2: v = dbl ? InfD | (v[0] ? NegZD : 0) : {v[63:32], v[0], 31'h7F80_0000};
      3: v = dbl ? (v[0] ? NegZD : 0) : {v[63:32], v[0], 31'h0};
      4: v = dbl ? {v[63], 11'h0, v[51:0]} : {v[63:32], v[31], 8'h0, v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) != 0 && c.op > OP_PTEST) c.op = OP_FP_PACK;
    c.lsz = 2'($urandom_range(0, 3));
    c.dbl = 1'($urandom_range(0, 1));
    c.pr = 3'($urandom_range(0, 7));
    c.alo = rand64();
    c.ahi = rand64();
    c.blo = rand64();
    c.bhi = rand64();
    if (c.op >= OP_FP_PACK && c.op <= OP_COMIS) begin
      c.alo = float_operand(c.dbl);
      c.ahi = float_operand(c.dbl);
      c.blo = $urandom_range(0, 3) == 0 ? c.alo : float_operand(c.dbl);
      c.bhi = $urandom_range(0, 3) == 0 ? c.ahi : float_operand(c.dbl);
    end else if ($urandom_range(0, 3) == 0) begin
      // partially equal lanes
      c.blo = c.alo ^ (rand64() & rand64() & rand64());
      c.bhi = c.ahi ^ (rand64() & rand64() & rand64());
    end else if (c.op == OP_PTEST && $urandom_range(0, 2) == 0) begin
      c.blo = $urandom_range(0, 1) ? ~c.alo : c.alo;
      c.bhi = $urandom_range(0, 1) ? ~c.ahi : c.ahi;
    end
    return c;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Drive one beat, after an optional idle gap, and wait for acceptance.
  task automatic send_beat(cmd_t c, res_t r);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= c.op;
    lane_size <= c.lsz;
    is_double <= c.dbl;
    pred <= c.pr;
    a_lo <= c.alo;
    a_hi <= c.ahi;
    b_lo <= c.blo;
    b_hi <= c.bhi;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(r);
    beats_in++;
  endtask

  row_t rows[$];

  // Stimulus: directed table then random beats.
  initial begin
    res_t z;
    cmd_t c;
    z = '{default: '0};
    rows = '{
      '{'{OP_INT_EQ, 2'd0, 1'b0, PR_EQ, '0, Ones, '0, Ones}, 1, '{Ones, Ones, 0, 0, 0, 0}},
      '{'{OP_INT_EQ, 2'd3, 1'b0, PR_EQ, '0, Ones, Ones, Ones}, 1, '{'0, Ones, 0, 0, 0, 0}},
      '{'{OP_INT_GT, 2'd0, 1'b0, PR_EQ, 64'h7F, '0, 64'h80, '0}, 1,
        '{64'hFF, '0, 0, 0, 0, 0}},
      '{'{OP_INT_GT, 2'd1, 1'b0, PR_EQ, 64'h8000, 1, '0, '0}, 0, z},
      '{'{OP_INT_GT, 2'd2, 1'b1, PR_ORD, rand64(), rand64(), rand64(), rand64()}, 0, z},
      '{'{OP_INT_GT, 2'd3, 1'b0, PR_EQ, 64'h7FFF_FFFF_FFFF_FFFF, NegZD, NegZD, '0}, 0, z},
      '{'{OP_FP_PACK, 2'd0, 1'b1, PR_EQ, '0, OneD, NegZD, OneD}, 1, '{Ones, Ones, 0, 0, 0, 0}},
      '{'{OP_FP_PACK, 2'd0, 1'b1, PR_LT, QNanD, OneD, OneD, InfD}, 0, z},
      '{'{OP_FP_PACK, 2'd2, 1'b1, PR_LE, SNanD, InfD, SNanD, InfD}, 0, z},
      '{'{OP_FP_PACK, 2'd0, 1'b1, PR_UNORD, QNanD, OneD, OneD, OneD}, 1,
        '{Ones, '0, 0, 0, 0, 0}},
      '{'{OP_FP_PACK, 2'd0, 1'b0, PR_NEQ, 64'h7FC0_0000_0000_0001, '0, '0, Ones}, 0, z},
      '{'{OP_FP_PACK, 2'd1, 1'b0, PR_NLT, 64'h0000_0001_8000_0000, '0, 1, '0}, 0, z},
      '{'{OP_FP_PACK, 2'd0, 1'b0, PR_NLE, 64'hFF80_0000_7F80_0000, '0, '0, '0}, 0, z},
      '{'{OP_FP_PACK, 2'd3, 1'b0, PR_ORD, 64'h7F80_0001_0000_0000, '0, '0, '0}, 0, z},
      '{'{OP_FP_SCAL, 2'd0, 1'b0, PR_EQ, 64'h1234_5678_0000_0000, Ones, 64'h8000_0000, '0},
        1, '{64'h1234_5678_FFFF_FFFF, Ones, 0, 0, 0, 0}},
      '{'{OP_FP_SCAL, 2'd0, 1'b1, PR_LT, 1, 64'h55, 2, '0}, 1, '{Ones, 64'h55, 0, 0, 0, 0}},
      '{'{OP_COMIS, 2'd0, 1'b1, PR_EQ, QNanD, '0, OneD, '0}, 1, '{'0, '0, 1, 1, 1, 1}},
      '{'{OP_COMIS, 2'd0, 1'b1, PR_EQ, NegZD, '0, '0, '0}, 1, '{'0, '0, 1, 1, 0, 0}},
      '{'{OP_COMIS, 2'd0, 1'b0, PR_EQ, 64'hBF80_0000, '0, 64'h3F80_0000, '0}, 1,
        '{'0, '0, 1, 0, 1, 0}},
      '{'{OP_PTEST, 2'd0, 1'b0, PR_EQ, Ones, Ones, '0, '0}, 1, '{'0, '0, 1, 1, 1, 0}},
      '{'{OP_PTEST, 2'd0, 1'b0, PR_EQ, '0, '0, Ones, Ones}, 1, '{'0, '0, 1, 1, 0, 0}},
      '{'{OP_PTEST, 2'd0, 1'b0, PR_EQ, Ones, Ones, Ones, Ones}, 1, '{'0, '0, 1, 0, 1, 0}},
      '{'{3'd6, 2'd3, 1'b1, PR_ORD, Ones, Ones, Ones, Ones}, 1, z},
      '{'{3'd7, 2'd0, 1'b0, PR_EQ, rand64(), rand64(), rand64(), rand64()}, 1, z}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      if (rows[i].known && compare_result(rows[i].c) != rows[i].r) begin
        $display("%0t: table row %0d exp %h predictor %h", $time, i, rows[i].r,
                 compare_result(rows[i].c));
        errors++;
      end
      send_beat(rows[i].c, rows[i].known ? rows[i].r : compare_result(rows[i].c));
    end
    for (int unsigned n = 0; n < NumRandom; n++) begin
      c = random_cmd();
      send_beat(c, compare_result(c));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Output stall: random, with one long hold-off that fills the pipe.
  initial begin
    out_stall <= 1'b1;
    @(negedge rst);
    while (!stim_done || pending_results.size() != 0) begin
      @(posedge clk);
      if (beats_in >= 60 && !hold_off) begin
        hold_off = 1'b1;
        out_stall <= 1'b1;
        repeat (40) @(posedge clk);
      end
      out_stall <= (gap_len() != 0);
    end
  end

  // Check each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result_lo !== e.rlo) begin
          $display("%0t: result_lo exp %h got %h", $time, e.rlo, result_lo);
          errors++;
        end
        if (result_hi !== e.rhi) begin
          $display("%0t: result_hi exp %h got %h", $time, e.rhi, result_hi);
          errors++;
        end
        if ({flags_written, zero_flag, carry_flag, parity_flag} !== {e.fw, e.zf, e.cf, e.pf})
        begin
          $display("%0t: flags fw/zf/cf/pf exp %b got %b", $time, {e.fw, e.zf, e.cf, e.pf},
                   {flags_written, zero_flag, carry_flag, parity_flag});
          errors++;
        end
      end
    end
  end

  // Run end and timeout.
  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (5) @(posedge clk);
    $display("Covered %0d beats in, %0d out: all ops, lane sizes, predicates, NaN/zero/inf.",
             beats_in, beats_out);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simd_compare_unit_core_test: clean");
    end else begin
      $display("simd_compare_unit_core_test: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("simd_compare_unit_core_test: errors");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/scu_pkg.sv
hw/rtl/scu_lane.sv
hw/rtl/scu_merge.sv
hw/rtl/simd_compare_unit_core.sv
hw/rtl/scu_checker.sv
verif/simd_compare_unit_core_test.sv
